>>> sv/kct_pkg.sv
// Package for the keyed count table: item and result types, operation codes,
// the stored slot format and the controller state type. No dependencies.
package kct_pkg;

	localparam int KEY_W = 10;
	localparam int CNT_W = 31;

	typedef enum logic [1:0] {
		OP_SET = 2'd0,
		OP_ADD = 2'd1,
		OP_SUB = 2'd2,
		OP_GET = 2'd3
	} op_t;

	typedef struct packed {
		op_t              operation;
		logic [KEY_W-1:0] key;
		logic [CNT_W-1:0] amount;
	} req_t;

	typedef struct packed {
		logic             ok;
		logic [CNT_W-1:0] count;
	} rsp_t;

	// One table entry as held in the slot memory.
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [CNT_W-1:0] count;
	} slot_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} state_t;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

endpackage

>>> sv/kct_mem.sv
// Slot memory for the keyed count table: one write port, one registered read
// port, and a valid flag per entry so that unwritten slots read as free.
// Depends on kct_pkg.
module kct_mem
	import kct_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  slot_t                                 wr_data,
	input  logic                                  rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output slot_t                                 rd_data
);

	slot_t            mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	slot_t            rd_data_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	// A slot never written since reset is free with a zero count.
	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

>>> sv/keyed_count_table.sv
// Keyed count table top level: controller, slot scan, read-modify-write and
// the result register. Depends on kct_pkg and kct_mem.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | req_t (operation, key, amount)
//  rsp     | out       | rsp_valid/rsp_stall | rsp_t (ok, count)
//
// An item is accepted in ST_IDLE, reads every slot in ST_SCAN through the single
// read port of the slot memory, and is written back in ST_UPDATE.
// One item is in work at a time; req_stall is high from acceptance until the
// result is loaded into the output register, which then waits for rsp_stall.
// Reset leaves every slot free at once through per-slot valid flags.
module keyed_count_table
	import kct_pkg::*;
#(
	parameter int SLOTS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int               IW   = SLOTS > 1 ? $clog2(SLOTS) : 1;
	localparam logic [IW-1:0]    LAST = IW'(SLOTS - 1);

	state_t          state_q, state_d;
	req_t            item_q;
	logic [IW-1:0]   scan_idx_q;
	logic [IW-1:0]   rd_idx_s1;
	logic            issue_done_q;
	logic            rvalid_s1, rlast_s1;
	logic            found_q, free_q;
	logic [IW-1:0]   hit_idx_q, free_idx_q;
	logic [CNT_W-1:0] hit_cnt_q;
	rsp_t            out_q;
	logic            out_valid_q;

	logic            accept, rd_en, upd_go;
	logic            do_write;
	logic [IW-1:0]   wr_addr;
	slot_t           wr_data, rd_data;
	rsp_t            res;
	logic [CNT_W:0]  sum;

	kct_mem #(.DEPTH(SLOTS)) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (upd_go && do_write),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (scan_idx_q),
		.rd_data (rd_data)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (rvalid_s1 && rlast_s1) state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (!out_valid_q || !rsp_stall) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Controller outputs
	always_comb begin
		req_stall = 1'b1;
		rd_en     = 1'b0;
		upd_go    = 1'b0;
		case (state_q)
			ST_IDLE:   req_stall = 1'b0;
			ST_SCAN:   rd_en     = !issue_done_q;
			ST_UPDATE: upd_go    = !out_valid_q || !rsp_stall;
			default:   req_stall = 1'b1;
		endcase
	end

	assign accept = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			scan_idx_q   <= '0;
			issue_done_q <= 1'b0;
			rvalid_s1    <= 1'b0;
			rlast_s1     <= 1'b0;
			found_q      <= 1'b0;
			free_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			rvalid_s1 <= rd_en;
			rlast_s1  <= rd_en && (scan_idx_q == LAST);
			if (accept) begin
				scan_idx_q   <= '0;
				issue_done_q <= 1'b0;
				found_q      <= 1'b0;
				free_q       <= 1'b0;
			end else begin
				if (rd_en) begin
					if (scan_idx_q == LAST) issue_done_q <= 1'b1;
					else scan_idx_q <= scan_idx_q + 1'b1;
				end
				// Keys are unique, so the first match is the only one; the
				// first free slot is the lowest-indexed one.
				if (rvalid_s1) begin
					if (!found_q && rd_data.key == item_q.key) found_q <= 1'b1;
					if (!free_q && rd_data.key == '0) free_q <= 1'b1;
				end
			end
			if (upd_go) out_valid_q <= 1'b1;
			else if (!rsp_stall) out_valid_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) item_q <= req;
		// The slot index travels alongside the registered read.
		if (rd_en) rd_idx_s1 <= scan_idx_q;
		if (rvalid_s1) begin
			if (!found_q && rd_data.key == item_q.key) begin
				hit_idx_q <= rd_idx_s1;
				hit_cnt_q <= rd_data.count;
			end
			if (!free_q && rd_data.key == '0) free_idx_q <= rd_idx_s1;
		end
		if (upd_go) out_q <= res;
	end

	// Read-modify-write of the chosen slot and the result
	always_comb begin
		sum      = {1'b0, hit_cnt_q} + {1'b0, item_q.amount};
		do_write = 1'b0;
		wr_addr  = hit_idx_q;
		wr_data  = '{key: item_q.key, count: item_q.amount};
		res      = '0;
		if (item_q.key != '0) begin
			case (item_q.operation)
				OP_SET, OP_ADD: begin
					if (found_q) begin
						do_write = 1'b1;
						res.ok   = 1'b1;
						if (item_q.operation == OP_ADD) begin
							wr_data.count = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
						end else if (item_q.amount == '0) begin
							// Setting a present key to zero frees its slot.
							wr_data.key = '0;
						end
						res.count = wr_data.count;
					end else if (free_q) begin
						do_write  = 1'b1;
						wr_addr   = free_idx_q;
						res.ok    = 1'b1;
						res.count = item_q.amount;
					end
				end
				OP_SUB: begin
					if (found_q) begin
						if (item_q.amount > hit_cnt_q) begin
							res.count = hit_cnt_q;
						end else begin
							do_write      = 1'b1;
							wr_data.count = hit_cnt_q - item_q.amount;
							res.ok        = 1'b1;
							res.count     = wr_data.count;
						end
					end
				end
				OP_GET: begin
					if (found_q) begin
						res.ok    = 1'b1;
						res.count = hit_cnt_q;
					end
				end
				default: res = '0;
			endcase
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	a_rsp_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q) == ST_UPDATE)
		else $error("result appeared without a write-back step");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rvalid_s1 |-> state_q == ST_SCAN)
		else $error("slot read returned outside the scan");

	a_write_nonzero_key: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_go && do_write) |-> item_q.key != '0)
		else $error("table written for an item with key zero");

	a_no_write_on_get: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_go && do_write) |-> item_q.operation != OP_GET)
		else $error("get item modified the table");

	a_idle_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		upd_go |=> state_q == ST_IDLE && rsp_valid)
		else $error("write-back did not complete the item");

endmodule
